// ----- design/ipv4_acl_chain_match_top_macros.svh -----
// Assertion macros shared by the ACL chain match block.
`ifndef IPV4_ACL_CHAIN_MATCH_TOP_MACROS_SVH
`define IPV4_ACL_CHAIN_MATCH_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ACL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/acl_pkg.sv -----
// Shared types and constants of the ACL chain match block.
package acl_pkg;

    localparam int unsigned RULE_COUNT = 256;
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned QCNT_W     = 2;

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_DELETE   = 2'd1;
    localparam logic [1:0] CMD_CLASSIFY = 2'd2;

    localparam logic [1:0] OP_NONE     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_DELETE   = 2'd2;
    localparam logic [1:0] OP_CLASSIFY = 2'd3;

    localparam logic [2:0] VERDICT_PASS = 3'd2;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [5:0]  src_prefix;
        logic [31:0] dst_addr;
        logic [5:0]  dst_prefix;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  proto;
        logic [2:0]  verdict;
        logic [7:0]  next_index;
    } t_rule;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] index;
        t_rule            rule;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } t_front_stat;

    typedef struct packed {
        logic idle;
    } t_back_stat;

endpackage

// ----- design/acl_front.sv -----
// Command decode and two-entry command queue of the ACL block.
module acl_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_cmd,
    input  logic [7:0]           i_rule_index,
    input  acl_pkg::t_rule       i_rule,
    input  logic                 i_pop,
    output acl_pkg::t_q_out      o_head,
    output acl_pkg::t_front_stat o_stat
);
    import acl_pkg::*;

    t_item             r_q [QDEPTH];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;
    logic              in_range;
    t_item             item;

    assign busy     = (r_count == QCNT_W'(QDEPTH));
    assign push     = start && !busy;
    assign pop      = i_pop && (r_count != '0);
    assign in_range = (32'(i_rule_index) < RULE_COUNT);

    // Turn the raw command into the operation the back end carries out.
    always_comb begin
        item.index = i_rule_index[IDX_W-1:0];
        item.rule  = i_rule;
        unique case (i_cmd)
            CMD_WRITE:    item.op = in_range ? OP_WRITE : OP_NONE;
            CMD_DELETE:   item.op = in_range ? OP_DELETE : OP_NONE;
            CMD_CLASSIFY: item.op = OP_CLASSIFY;
            default:      item.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_q[r_rd_ptr];
    assign o_stat.count = r_count;

endmodule

// ----- design/acl_back.sv -----
// Rule table and chain-walk sequencer of the ACL block.
module acl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  acl_pkg::t_q_out     i_head,
    output logic                o_pop,
    output logic                o_strobe,
    output logic [2:0]          o_verdict,
    output logic                o_matched,
    output logic [7:0]          o_matched_rule,
    output acl_pkg::t_back_stat o_stat
);
    import acl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HEAD = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    t_rule                r_mem [RULE_COUNT];
    t_rule                r_rdata;
    logic [RULE_COUNT-1:0] r_valid;
    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [IDX_W-1:0]     r_cur;
    logic [IDX_W-1:0]     n_cur;
    t_rule                r_tup;
    logic                 r_strobe;
    logic                 n_strobe;
    logic [2:0]           r_verdict;
    logic [2:0]           n_verdict;
    logic                 r_matched;
    logic                 n_matched;
    logic [7:0]           r_rule;
    logic [7:0]           n_rule;
    logic                 mem_we;
    logic                 mem_re;
    logic [IDX_W-1:0]     rd_addr;
    logic                 take;
    logic                 hit;
    logic                 link_ok;

    function automatic logic cidr_hit(input logic [31:0] addr, input logic [31:0] net,
                                      input logic [5:0] len);
        logic [5:0]  sat;
        logic [31:0] mask;
        sat  = (len > 6'd32) ? 6'd32 : len;
        mask = (sat == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - sat));
        return (addr & mask) == (net & mask);
    endfunction

    assign hit = cidr_hit(r_tup.src_addr, r_rdata.src_addr, r_rdata.src_prefix)
              && cidr_hit(r_tup.dst_addr, r_rdata.dst_addr, r_rdata.dst_prefix)
              && (r_rdata.src_port == '0 || r_rdata.src_port == r_tup.src_port)
              && (r_rdata.dst_port == '0 || r_rdata.dst_port == r_tup.dst_port)
              && (r_rdata.proto == '0 || r_rdata.proto == r_tup.proto);

    // A link is followed only forward and only inside the table.
    assign link_ok = (r_rdata.next_index > r_cur)
                  && (32'(r_rdata.next_index) < RULE_COUNT);

    assign take = (r_state == S_IDLE) && i_head.valid;

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_strobe  = 1'b0;
        n_verdict = VERDICT_PASS;
        n_matched = 1'b0;
        n_rule    = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        rd_addr   = r_rdata.next_index[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_head.item.op == OP_WRITE) begin
                        mem_we = 1'b1;
                    end
                    if (i_head.item.op == OP_CLASSIFY && r_valid[0]) begin
                        mem_re  = 1'b1;
                        rd_addr = '0;
                        n_cur   = '0;
                        n_state = S_HEAD;
                    end else begin
                        n_strobe = 1'b1;
                    end
                end
            end
            S_HEAD: begin
                if (link_ok) begin
                    mem_re  = 1'b1;
                    n_cur   = r_rdata.next_index[IDX_W-1:0];
                    n_state = S_WALK;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_WALK: begin
                if (!r_valid[r_cur]) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (hit) begin
                    n_strobe  = 1'b1;
                    n_verdict = r_rdata.verdict;
                    n_matched = 1'b1;
                    n_rule    = 8'(r_cur);
                    n_state   = S_IDLE;
                end else if (link_ok) begin
                    mem_re = 1'b1;
                    n_cur  = r_rdata.next_index[IDX_W-1:0];
                end else begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_head.item.index] <= i_head.item.rule;
        end
        if (mem_re) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (take) begin
            r_tup <= i_head.item.rule;
        end
        r_cur     <= n_cur;
        r_verdict <= n_verdict;
        r_matched <= n_matched;
        r_rule    <= n_rule;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (take && i_head.item.op == OP_WRITE) begin
                r_valid[i_head.item.index] <= 1'b1;
            end
            if (take && i_head.item.op == OP_DELETE) begin
                r_valid[i_head.item.index] <= 1'b0;
            end
        end
    end

    assign o_pop          = take;
    assign o_strobe       = r_strobe;
    assign o_verdict      = r_verdict;
    assign o_matched      = r_matched;
    assign o_matched_rule = r_rule;
    assign o_stat.idle    = (r_state == S_IDLE);

endmodule

// ----- design/ipv4_acl_chain_match_top.sv -----
// Top level of the first-match IPv4 five-tuple ACL with a linked rule table.
//
// Usage: a command is transferred at a rising edge where start is high and
// busy is low. i_cmd selects write rule, delete rule or classify tuple; the
// other input ports carry the rule or the tuple. Every command, including an
// unused code, yields exactly one result: o_strobe is high for one cycle
// with o_verdict, o_matched and o_matched_rule valid. Results come back in
// command order and must be taken in that cycle.
//
// Structure: a front end decodes commands into a two-entry queue, so busy
// only rises when both entries wait. The back end takes one command at a
// time. The result of a write, delete, unused command or a classify with
// no head entry is registered as the back end takes it from the queue.
// Otherwise a classify reads the head entry and then one chained rule per
// cycle from the rule memory, whose single read port sets the pace; a walk
// visits at most 255 rules after the head.
//
// Reset clears all rule valid bits, the queue and the sequencer. Rule
// contents are not cleared; an entry is only used while it is valid.
module ipv4_acl_chain_match_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_rule_index,
    input  logic [31:0] i_src_addr,
    input  logic [5:0]  i_src_prefix,
    input  logic [31:0] i_dst_addr,
    input  logic [5:0]  i_dst_prefix,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_proto,
    input  logic [2:0]  i_rule_verdict,
    input  logic [7:0]  i_next_index,
    output logic        o_strobe,
    output logic [2:0]  o_verdict,
    output logic        o_matched,
    output logic [7:0]  o_matched_rule
);
    import acl_pkg::*;

    `include "ipv4_acl_chain_match_top_macros.svh"

    t_rule       in_rule;
    t_q_out      head;
    logic        pop;
    t_front_stat front_stat;
    t_back_stat  back_stat;

    // The same record carries a rule for a write and the tuple for a classify.
    always_comb begin
        in_rule.src_addr   = i_src_addr;
        in_rule.src_prefix = i_src_prefix;
        in_rule.dst_addr   = i_dst_addr;
        in_rule.dst_prefix = i_dst_prefix;
        in_rule.src_port   = i_src_port;
        in_rule.dst_port   = i_dst_port;
        in_rule.proto      = i_proto;
        in_rule.verdict    = i_rule_verdict;
        in_rule.next_index = i_next_index;
    end

    acl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_rule_index (i_rule_index),
        .i_rule       (in_rule),
        .i_pop        (pop),
        .o_head       (head),
        .o_stat       (front_stat)
    );

    acl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .o_pop          (pop),
        .o_strobe       (o_strobe),
        .o_verdict      (o_verdict),
        .o_matched      (o_matched),
        .o_matched_rule (o_matched_rule),
        .o_stat         (back_stat)
    );

    // A result without a match is always the default pass on no rule.
    `ACL_ASSERT_SAME(a_nomatch_pass, o_strobe && !o_matched, o_verdict == VERDICT_PASS && o_matched_rule == 8'd0, "unmatched result is not a plain pass")
    // The head entry is never matched, so a hit names a later rule.
    `ACL_ASSERT_SAME(a_match_not_head, o_strobe && o_matched, o_matched_rule != 8'd0, "head entry reported as match")
    // A full queue drains one entry as soon as the back end is idle.
    `ACL_ASSERT_NEXT(a_full_drains, front_stat.count == QCNT_W'(QDEPTH) && back_stat.idle, !busy, "queue did not drain to idle back end")

endmodule

// ----- bench/acl_decision_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the ACL chain match block: mirrors the rule table and checks every result.
module acl_decision_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_rule_index,
    input  logic [31:0] i_src_addr,
    input  logic [5:0]  i_src_prefix,
    input  logic [31:0] i_dst_addr,
    input  logic [5:0]  i_dst_prefix,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_proto,
    input  logic [2:0]  i_rule_verdict,
    input  logic [7:0]  i_next_index,
    input  logic        i_strobe,
    input  logic [2:0]  i_verdict,
    input  logic        i_matched,
    input  logic [7:0]  i_matched_rule,
    output int          o_failures,
    output int          o_outstanding
);
    import acl_pkg::*;

    typedef struct packed {
        logic [2:0] verdict;
        logic       matched;
        logic [7:0] matched_rule;
    } t_decision;

    t_rule     rule_table [RULE_COUNT];
    bit        rule_live [RULE_COUNT];
    t_decision pending_decisions [$];
    int        failures = 0;

    assign o_failures = failures;

    // A zero prefix covers every address; lengths past 32 act as an exact /32 match.
    function automatic bit network_hit(input logic [31:0] addr, input logic [31:0] net,
                                       input logic [5:0] len);
        logic [31:0] mask;
        int          bits;
        if (len == 6'd0) return 1'b1;
        bits = (len > 6'd32) ? 32 : int'(len);
        mask = 32'hFFFF_FFFF << (32 - bits);
        return (addr & mask) == (net & mask);
    endfunction

    function automatic bit port_hit(input logic [15:0] have, input logic [15:0] want);
        return (want == 16'd0) || (want == have);
    endfunction

    // First-match walk from the head entry along strictly ascending links.
    function automatic t_decision predict_decision(input logic [31:0] sa, input logic [31:0] da,
                                                   input logic [15:0] sp, input logic [15:0] dp,
                                                   input logic [7:0] pr);
        t_decision d;
        t_rule     r;
        int        cur;
        int        nxt;
        d.verdict      = VERDICT_PASS;
        d.matched      = 1'b0;
        d.matched_rule = 8'd0;
        if (!rule_live[0]) return d;
        cur = 0;
        nxt = int'(rule_table[0].next_index);
        while (nxt != 0 && nxt > cur && nxt < int'(RULE_COUNT)) begin
            cur = nxt;
            if (!rule_live[cur]) break;
            r = rule_table[cur];
            if (network_hit(sa, r.src_addr, r.src_prefix) &&
                network_hit(da, r.dst_addr, r.dst_prefix) &&
                port_hit(sp, r.src_port) && port_hit(dp, r.dst_port) &&
                port_hit({8'd0, pr}, {8'd0, r.proto})) begin
                d.verdict      = r.verdict;
                d.matched      = 1'b1;
                d.matched_rule = 8'(cur);
                return d;
            end
            nxt = int'(r.next_index);
        end
        return d;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_decision want;
        if (!i_rst_n) begin
            foreach (rule_live[k]) rule_live[k] = 1'b0;
            pending_decisions.delete();
            o_outstanding <= 0;
        end else begin
            if (i_start && !i_busy) begin
                case (i_cmd)
                    CMD_WRITE: begin
                        rule_live[i_rule_index]  = 1'b1;
                        rule_table[i_rule_index] = '{i_src_addr, i_src_prefix, i_dst_addr,
                                                     i_dst_prefix, i_src_port, i_dst_port,
                                                     i_proto, i_rule_verdict, i_next_index};
                    end
                    CMD_DELETE: begin
                        rule_live[i_rule_index] = 1'b0;
                    end
                    default: ;
                endcase
                if (i_cmd == CMD_CLASSIFY)
                    want = predict_decision(i_src_addr, i_dst_addr, i_src_port, i_dst_port,
                                            i_proto);
                else
                    want = '{VERDICT_PASS, 1'b0, 8'd0};
                pending_decisions.push_back(want);
            end
            if (i_strobe) begin
                if (pending_decisions.size() == 0) begin
                    failures++;
                    $display("%0t: result expected none, got verdict %0d matched %0d rule %0d",
                             $time, i_verdict, i_matched, i_matched_rule);
                end else begin
                    want = pending_decisions.pop_front();
                    check_field("verdict", {5'd0, want.verdict}, {5'd0, i_verdict});
                    check_field("matched", {7'd0, want.matched}, {7'd0, i_matched});
                    check_field("matched_rule", want.matched_rule, i_matched_rule);
                end
            end
            o_outstanding <= pending_decisions.size();
        end
    end

endmodule

// ----- bench/ipv4_acl_chain_match_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the ACL chain match block: stimulus, clock, reset and the final verdict.
module ipv4_acl_chain_match_top_tb;
    import acl_pkg::*;

    // The command port has one code that the block must treat as a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Rule actions used by the directed part. Codes 5 to 7 are not defined
    // actions, but the block must store and return them unchanged.
    localparam logic [2:0] VERDICT_ABORT    = 3'd0;
    localparam logic [2:0] VERDICT_DROP     = 3'd1;
    localparam logic [2:0] VERDICT_TX       = 3'd3;
    localparam logic [2:0] VERDICT_REDIRECT = 3'd4;
    localparam logic [2:0] VERDICT_RSVD_5   = 3'd5;
    localparam logic [2:0] VERDICT_RSVD_7   = 3'd7;

    localparam int RANDOM_ITEMS = 400;

    // One command as the sender sees it. For a classify, the tuple rides in
    // the address, port and protocol fields of the rule.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] index;
        t_rule      rule;
    } t_acl_command;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd          = CMD_WRITE;
    logic [7:0]  i_rule_index   = 8'd0;
    logic [31:0] i_src_addr     = 32'd0;
    logic [5:0]  i_src_prefix   = 6'd0;
    logic [31:0] i_dst_addr     = 32'd0;
    logic [5:0]  i_dst_prefix   = 6'd0;
    logic [15:0] i_src_port     = 16'd0;
    logic [15:0] i_dst_port     = 16'd0;
    logic [7:0]  i_proto        = 8'd0;
    logic [2:0]  i_rule_verdict = VERDICT_PASS;
    logic [7:0]  i_next_index   = 8'd0;
    logic        o_strobe;
    logic [2:0]  o_verdict;
    logic        o_matched;
    logic [7:0]  o_matched_rule;

    int failures;
    int outstanding;

    // Copy of what was written, kept by the sender only so that it can aim
    // classify tuples at stored rules. The checker keeps its own table.
    t_rule shadow_rule [RULE_COUNT];
    bit    shadow_written [RULE_COUNT];

    // Next entry of the chain that the random part keeps extending upward.
    int chain_cursor = 1;

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    ipv4_acl_chain_match_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_rule_index   (i_rule_index),
        .i_src_addr     (i_src_addr),
        .i_src_prefix   (i_src_prefix),
        .i_dst_addr     (i_dst_addr),
        .i_dst_prefix   (i_dst_prefix),
        .i_src_port     (i_src_port),
        .i_dst_port     (i_dst_port),
        .i_proto        (i_proto),
        .i_rule_verdict (i_rule_verdict),
        .i_next_index   (i_next_index),
        .o_strobe       (o_strobe),
        .o_verdict      (o_verdict),
        .o_matched      (o_matched),
        .o_matched_rule (o_matched_rule)
    );

    acl_decision_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (i_cmd),
        .i_rule_index   (i_rule_index),
        .i_src_addr     (i_src_addr),
        .i_src_prefix   (i_src_prefix),
        .i_dst_addr     (i_dst_addr),
        .i_dst_prefix   (i_dst_prefix),
        .i_src_port     (i_src_port),
        .i_dst_port     (i_dst_port),
        .i_proto        (i_proto),
        .i_rule_verdict (i_rule_verdict),
        .i_next_index   (i_next_index),
        .i_strobe       (o_strobe),
        .i_verdict      (o_verdict),
        .i_matched      (o_matched),
        .i_matched_rule (o_matched_rule),
        .o_failures     (failures),
        .o_outstanding  (outstanding)
    );

    function automatic t_acl_command make_command(
        input logic [1:0]  cmd,
        input logic [7:0]  index,
        input logic [31:0] src_addr,
        input logic [5:0]  src_prefix,
        input logic [31:0] dst_addr,
        input logic [5:0]  dst_prefix,
        input logic [15:0] src_port,
        input logic [15:0] dst_port,
        input logic [7:0]  proto,
        input logic [2:0]  verdict,
        input logic [7:0]  nxt_index
    );
        t_acl_command c;
        c.cmd   = cmd;
        c.index = index;
        c.rule  = '{src_addr, src_prefix, dst_addr, dst_prefix, src_port, dst_port, proto,
                    verdict, nxt_index};
        return c;
    endfunction

    // Mostly real CIDR lengths, now and then the match-all zero, and now and
    // then an oversized length that the block has to treat as /32.
    function automatic logic [5:0] random_prefix();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 6'd0;
        if (r == 1) return 6'($urandom_range(33, 63));
        return 6'($urandom_range(1, 32));
    endfunction

    // Address bits that a rule of the given prefix length does not look at.
    function automatic logic [31:0] host_bits(input logic [5:0] len);
        if (len == 6'd0) return 32'hFFFF_FFFF;
        if (len >= 6'd32) return 32'd0;
        return 32'hFFFF_FFFF >> len;
    endfunction

    // The random mix. Writes mostly extend one ascending chain so that the
    // walk goes deep, the head is rewritten now and then to restart it, and
    // most classify tuples are aimed at a stored rule so that matches happen
    // at every depth. The rest is deletes, the unused code and plain noise.
    function automatic t_acl_command random_command();
        t_acl_command c;
        t_rule        base;
        int           pick;
        int           r;
        int           step;
        int           target;
        int           tries;
        pick               = $urandom_range(0, 99);
        c.index            = 8'($urandom_range(0, 255));
        c.rule.src_addr    = $urandom;
        c.rule.dst_addr    = $urandom;
        c.rule.src_prefix  = random_prefix();
        c.rule.dst_prefix  = random_prefix();
        c.rule.src_port    = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
        c.rule.dst_port    = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
        c.rule.proto       = $urandom_range(0, 1) ? 8'($urandom) : 8'd0;
        c.rule.verdict     = 3'($urandom_range(0, 7));
        c.rule.next_index  = 8'($urandom_range(0, 255));
        if (pick < 35) begin
            c.cmd = CMD_WRITE;
            r     = $urandom_range(0, 99);
            if (r < 5) begin
                c.index           = 8'd0;
                c.rule.next_index = 8'($urandom_range(1, 8));
            end else if (r < 75) begin
                c.index = 8'(chain_cursor);
                step    = $urandom_range(1, 6);
                if (chain_cursor + step > 255) begin
                    c.rule.next_index = 8'd0;
                    chain_cursor      = $urandom_range(1, 8);
                end else begin
                    chain_cursor      = chain_cursor + step;
                    c.rule.next_index = 8'(chain_cursor);
                end
            end
        end else if (pick < 40) begin
            c.cmd = CMD_DELETE;
        end else if (pick < 43) begin
            c.cmd = CMD_UNUSED;
        end else begin
            c.cmd = CMD_CLASSIFY;
            if ($urandom_range(0, 3) != 0) begin
                target = $urandom_range(1, 255);
                tries  = 0;
                while (!shadow_written[target] && tries < 32) begin
                    target = $urandom_range(1, 255);
                    tries++;
                end
                if (shadow_written[target]) begin
                    base            = shadow_rule[target];
                    c.rule.src_addr = base.src_addr ^ ($urandom & host_bits(base.src_prefix));
                    c.rule.dst_addr = base.dst_addr ^ ($urandom & host_bits(base.dst_prefix));
                    if (base.src_port != 16'd0) c.rule.src_port = base.src_port;
                    if (base.dst_port != 16'd0) c.rule.dst_port = base.dst_port;
                    if (base.proto != 8'd0) c.rule.proto = base.proto;
                    // A near miss: one address bit off.
                    if ($urandom_range(0, 9) == 0)
                        c.rule.src_addr[$urandom_range(0, 31)] ^= 1'b1;
                end
            end
        end
        return c;
    endfunction

    // Present a command and hold it until the block takes it. The caller is
    // just past a rising edge, so start is raised by a single nonblocking
    // assignment in this step; busy is sampled as it stood before the edge.
    task automatic issue_command(input t_acl_command c);
        i_cmd          <= c.cmd;
        i_rule_index   <= c.index;
        i_src_addr     <= c.rule.src_addr;
        i_src_prefix   <= c.rule.src_prefix;
        i_dst_addr     <= c.rule.dst_addr;
        i_dst_prefix   <= c.rule.dst_prefix;
        i_src_port     <= c.rule.src_port;
        i_dst_port     <= c.rule.dst_port;
        i_proto        <= c.rule.proto;
        i_rule_verdict <= c.rule.verdict;
        i_next_index   <= c.rule.next_index;
        start          <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (c.cmd == CMD_WRITE) begin
            shadow_rule[c.index]    = c.rule;
            shadow_written[c.index] = 1'b1;
        end
    endtask

    initial begin : stimulus
        int sent;
        int burst;
        int gap;
        int r;

        // Synchronous reset held, then released once for good.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With no head entry every classify falls through to pass.
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'd0, 6'd0, 32'd0, 6'd0,
                                   16'd0, 16'd0, 8'd0, VERDICT_ABORT, 8'd0));
        // The head carries only its link; everything else in it is ignored,
        // including an oversized prefix and the abort action.
        issue_command(make_command(CMD_WRITE, 8'd0, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 6'd63,
                                   16'hFFFF, 16'hFFFF, 8'hFF, VERDICT_ABORT, 8'd3));
        // Entry 3: 10.0.0.0/8 source, match-all destination, TCP, drop.
        issue_command(make_command(CMD_WRITE, 8'd3, 32'h0A00_0000, 6'd8, 32'hFFFF_FFFF, 6'd0,
                                   16'd0, 16'd0, 8'd6, VERDICT_DROP, 8'd7));
        // Entry 7: exact source, oversized destination prefix, fixed ports,
        // any protocol, an undefined action code and a link to itself.
        issue_command(make_command(CMD_WRITE, 8'd7, 32'hC0A8_0101, 6'd32, 32'h0808_0808, 6'd40,
                                   16'hFFFF, 16'd80, 8'd0, VERDICT_RSVD_7, 8'd7));
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'h0A01_0203, 6'd0, 32'h1234_5678, 6'd0,
                                   16'd1000, 16'd443, 8'd6, VERDICT_ABORT, 8'd0));
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'hC0A8_0101, 6'd0, 32'h0808_0808, 6'd0,
                                   16'hFFFF, 16'd80, 8'd17, VERDICT_ABORT, 8'd0));
        // Destination one bit off: entry 7 misses and its self link ends the walk.
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'hC0A8_0101, 6'd0, 32'h0808_0809, 6'd0,
                                   16'hFFFF, 16'd80, 8'd17, VERDICT_ABORT, 8'd0));
        // A backward link from 7 to a catch-all entry 5 must not be followed.
        issue_command(make_command(CMD_WRITE, 8'd7, 32'hC0A8_0101, 6'd32, 32'h0808_0808, 6'd40,
                                   16'hFFFF, 16'd80, 8'd0, VERDICT_REDIRECT, 8'd5));
        issue_command(make_command(CMD_WRITE, 8'd5, 32'h5555_AAAA, 6'd0, 32'hAAAA_5555, 6'd0,
                                   16'd0, 16'd0, 8'd0, VERDICT_TX, 8'd0));
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'hC0A8_0101, 6'd0, 32'h0808_0809, 6'd0,
                                   16'hFFFF, 16'd80, 8'd17, VERDICT_ABORT, 8'd0));
        // Forward link to a catch-all at 200, then take 200 away again.
        issue_command(make_command(CMD_WRITE, 8'd7, 32'hC0A8_0101, 6'd32, 32'h0808_0808, 6'd40,
                                   16'hFFFF, 16'd80, 8'd0, VERDICT_REDIRECT, 8'd200));
        issue_command(make_command(CMD_WRITE, 8'd200, 32'd0, 6'd0, 32'd0, 6'd0,
                                   16'd0, 16'd0, 8'd0, VERDICT_ABORT, 8'd0));
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'hC0A8_0101, 6'd0, 32'h0808_0809, 6'd0,
                                   16'hFFFF, 16'd80, 8'd17, VERDICT_ABORT, 8'd0));
        issue_command(make_command(CMD_DELETE, 8'd200, 32'd0, 6'd0, 32'd0, 6'd0,
                                   16'd0, 16'd0, 8'd0, VERDICT_ABORT, 8'd0));
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'hC0A8_0101, 6'd0, 32'h0808_0809, 6'd0,
                                   16'hFFFF, 16'd80, 8'd17, VERDICT_ABORT, 8'd0));
        // The top entry of the table as a catch-all with another undefined code,
        // reached through a rewritten 200 that only takes protocol 1.
        issue_command(make_command(CMD_WRITE, 8'd255, 32'h0000_0001, 6'd0, 32'h8000_0000, 6'd0,
                                   16'd0, 16'd0, 8'd0, VERDICT_RSVD_5, 8'd0));
        issue_command(make_command(CMD_WRITE, 8'd200, 32'd0, 6'd0, 32'd0, 6'd0,
                                   16'd0, 16'd0, 8'd1, VERDICT_DROP, 8'd255));
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'hC0A8_0101, 6'd0, 32'h0808_0809, 6'd0,
                                   16'hFFFF, 16'd80, 8'd6, VERDICT_ABORT, 8'd0));
        // The unused code must leave entry 3 alone.
        issue_command(make_command(CMD_UNUSED, 8'd3, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 6'd63,
                                   16'hFFFF, 16'hFFFF, 8'hFF, VERDICT_RSVD_7, 8'hFF));
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'h0A01_0203, 6'd0, 32'h1234_5678, 6'd0,
                                   16'd1000, 16'd443, 8'd6, VERDICT_ABORT, 8'd0));
        // Without a head nothing is walked; a head that links to 0 ends at once.
        issue_command(make_command(CMD_DELETE, 8'd0, 32'd0, 6'd0, 32'd0, 6'd0,
                                   16'd0, 16'd0, 8'd0, VERDICT_ABORT, 8'd0));
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'h0A01_0203, 6'd0, 32'h1234_5678, 6'd0,
                                   16'd1000, 16'd443, 8'd6, VERDICT_ABORT, 8'd0));
        issue_command(make_command(CMD_WRITE, 8'd0, 32'd0, 6'd0, 32'd0, 6'd0,
                                   16'd0, 16'd0, 8'd0, VERDICT_PASS, 8'd0));
        issue_command(make_command(CMD_CLASSIFY, 8'd0, 32'h0A01_0203, 6'd0, 32'h1234_5678, 6'd0,
                                   16'd1000, 16'd443, 8'd6, VERDICT_ABORT, 8'd0));

        // Random part, sent in bursts. Back-to-back transfers fill the
        // two-entry command queue so that busy gets exercised; short gaps
        // land inside a walk, long ones let the block drain completely.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                issue_command(random_command());
                sent++;
            end
            r = $urandom_range(0, 9);
            if (r < 2)
                gap = 0;
            else if (r < 8)
                gap = $urandom_range(1, 20);
            else
                gap = $urandom_range(20, 300);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        // Drain: every transfer owes one result. After the last one, keep watching
        // for any stray strobe before the verdict is printed.
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0)
            $display("ipv4_acl_chain_match_top_tb: clean");
        else
            $display("ipv4_acl_chain_match_top_tb: errors");
        $finish;
    end

    // Watchdog. The slowest legal run (every classify walking the whole table
    // plus the longest sender gaps) stays well under a tenth of this.
    initial begin : watchdog
        #50_000_000;
        $display("ipv4_acl_chain_match_top_tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/acl_pkg.sv
design/acl_front.sv
design/acl_back.sv
design/ipv4_acl_chain_match_top.sv
bench/acl_decision_checker.sv
bench/ipv4_acl_chain_match_top_tb.sv
